/* src/sha256_stream_hasher_core_macros.svh */
// Assertion macros shared by the SHA-256 hasher checker.
// No dependencies; expects clk and rst in the scope of use.
`ifndef SHA256_STREAM_HASHER_CORE_MACROS_SVH
`define SHA256_STREAM_HASHER_CORE_MACROS_SVH

// same-cycle implication
`define SHA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SHA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/sha256_pkg.sv */
// SHA-256 hasher package: sequencer states, round constants, initial hash
// values and the sigma functions. No dependencies.
package sha256_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FINAL,
    ST_DONE
  } state_t;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

/* src/sha256_stream_hasher_core.sv */
// SHA-256 byte-stream hasher. Uses sha256_pkg.
// A byte is taken while the sequencer idles; a byte that fills a block starts
// the rounds, then a finalize step. Throughput is set by the single shared
// round unit, as no byte is taken while a block is compressed. An end-of-message
// transaction pushes 9 to 72 pad bytes at one per cycle, one or two compressions,
// then loads the digest register. Reset (synchronous) idles the sequencer,
// loads the initial hash, clears counts; block buffer is not cleared.
module sha256_stream_hasher_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  msg_byte,
  input  logic        has_byte,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] digest_w01,
  output logic [63:0] digest_w23,
  output logic [63:0] digest_w45,
  output logic [63:0] digest_w67
);
  import sha256_pkg::*;

  state_t        state, state_next;
  logic [511:0]  blk;        // byte buffer, then schedule window W[t..t+15]
  logic [5:0]    fill;
  logic [63:0]   bits;
  logic [5:0]    rnd;
  logic          pad_on, sent80, len_done;
  logic          pad_wrap;   // 0x80 landed at offset 56..62, length goes in next block
  logic [31:0]   hash [8];
  logic [31:0]   v [8];

  logic          push;
  logic [7:0]    push_byte;
  logic [7:0]    pad_byte;
  logic [63:0]   len_shift;
  logic [31:0]   w0, w1, w9, w14, w_new;
  logic [31:0]   t1, t2;
  logic          out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  assign w0  = blk[511 -: 32];
  assign w1  = blk[479 -: 32];
  assign w9  = blk[223 -: 32];
  assign w14 = blk[63 -: 32];
  assign w_new = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;

  assign t1 = v[7] + big_sigma1(v[4]) + ((v[4] & v[5]) ^ (~v[4] & v[6]))
            + ROUND_K[rnd] + w0;
  assign t2 = big_sigma0(v[0]) + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  // big-endian length byte at offsets 56..63
  assign len_shift = bits >> {~fill[2:0], 3'b000};

  always_comb begin
    if (!sent80) begin
      pad_byte = PAD_MARK;
    end else if ((fill < LEN_OFFSET) || pad_wrap) begin
      pad_byte = 8'h00;
    end else begin
      pad_byte = len_shift[7:0];
    end
  end

  always_comb begin
    state_next = state;
    push       = 1'b0;
    push_byte  = msg_byte;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          push = has_byte;
          if (has_byte && (fill == 6'd63)) begin
            state_next = ST_ROUND;
          end else if (end_of_message) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        push      = 1'b1;
        push_byte = pad_byte;
        if (fill == 6'd63) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (rnd == 6'd63) begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (pad_on && len_done) begin
          state_next = ST_DONE;
        end else if (pad_on) begin
          state_next = ST_PAD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      bits      <= '0;
      rnd       <= '0;
      pad_on    <= 1'b0;
      sent80    <= 1'b0;
      len_done  <= 1'b0;
      pad_wrap  <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < 8; i++) hash[i] <= H_INIT[i];
    end else begin
      state <= state_next;

      if (push) begin
        blk  <= {blk[503:0], push_byte};
        fill <= fill + 6'd1;
      end

      if ((state == ST_IDLE) && in_valid) begin
        if (has_byte) bits <= bits + 64'd8;
        if (end_of_message) pad_on <= 1'b1;
      end

      if (state == ST_PAD) begin
        sent80 <= 1'b1;
        if (!sent80) begin
          pad_wrap <= (fill >= LEN_OFFSET) && (fill != 6'd63);
        end else if (fill == 6'd63) begin
          pad_wrap <= 1'b0;
        end
        if (sent80 && !pad_wrap && (fill == 6'd63)) len_done <= 1'b1;
      end

      if ((state_next == ST_ROUND) && (state != ST_ROUND)) begin
        rnd <= '0;
        for (int i = 0; i < 8; i++) v[i] <= hash[i];
      end

      if (state == ST_ROUND) begin
        blk  <= {blk[479:0], w_new};
        rnd  <= rnd + 6'd1;
        v[0] <= t1 + t2;
        v[1] <= v[0];
        v[2] <= v[1];
        v[3] <= v[2];
        v[4] <= v[3] + t1;
        v[5] <= v[4];
        v[6] <= v[5];
        v[7] <= v[6];
      end

      if (state == ST_FINAL) begin
        for (int i = 0; i < 8; i++) hash[i] <= hash[i] + v[i];
      end

      if ((state == ST_DONE) && out_free) begin
        digest_w01 <= {hash[0], hash[1]};
        digest_w23 <= {hash[2], hash[3]};
        digest_w45 <= {hash[4], hash[5]};
        digest_w67 <= {hash[6], hash[7]};
        out_valid  <= 1'b1;
        bits       <= '0;
        pad_on     <= 1'b0;
        sent80     <= 1'b0;
        len_done   <= 1'b0;
        for (int i = 0; i < 8; i++) hash[i] <= H_INIT[i];
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* src/sha256_chk.sv */
// Port-level checker for sha256_stream_hasher_core, bound to every instance of it.
// Depends on sha256_stream_hasher_core_macros.svh.
`include "sha256_stream_hasher_core_macros.svh"

module sha256_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        has_byte,
  input logic        end_of_message,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] digest_w01,
  input logic [63:0] digest_w23,
  input logic [63:0] digest_w45,
  input logic [63:0] digest_w67
);

  logic         in_txn;
  logic         idle_txn;
  logic         eom_txn;
  logic         out_stall;
  logic [255:0] digest_all;

  assign in_txn     = in_valid && in_ready;
  assign idle_txn   = in_txn && !has_byte && !end_of_message;
  assign eom_txn    = in_txn && end_of_message;
  assign out_stall  = out_valid && !out_ready;
  assign digest_all = {digest_w01, digest_w23, digest_w45, digest_w67};

  `SHA_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(digest_all), "digest not held")
  `SHA_ASSERT_NEXT(a_empty_txn, idle_txn, in_ready, "empty transaction left the block busy")
  `SHA_ASSERT_NEXT(a_eom_busy, eom_txn, !in_ready, "end of message did not start padding")
  `SHA_ASSERT_NOW(a_digest_source, $rose(out_valid), $past(!in_ready), "digest with no busy cycle")

endmodule

bind sha256_stream_hasher_core sha256_chk u_sha256_chk (.*);
